FILE: hw/rtl/bcds_pkg.sv
`timescale 1ns / 1ps

package bcds_pkg;

    localparam int BCDS_SAMPLE_BITS   = 16;
    localparam int BCDS_FRACTION_BITS = 8;

    // bit depth and hold length limits
    localparam logic [4:0] CRUSH_MAX = 5'd16;
    localparam logic [4:0] HOLD_MAX  = 5'd30;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CRUSH_BITS    = 3'd0,
        CFG_CRUSH_FRACTION = 3'd1,
        CFG_HOLD_LENGTH   = 3'd2,
        CFG_HOLD_FRACTION = 3'd3,
        CFG_WET_AMOUNT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRUSH_L,
        ST_CRUSH_R,
        ST_WET_L,
        ST_WET_R,
        ST_HOLD_L,
        ST_HOLD_R,
        ST_HOLD_FIN,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/bcds_quant.sv
`timescale 1ns / 1ps

module bcds_quant #(
    parameter int SAMPLE_BITS = bcds_pkg::BCDS_SAMPLE_BITS
) (
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic        [4:0]             i_levels_log2,
    output logic signed [SAMPLE_BITS-1:0] o_q
);
    import bcds_pkg::*;

    logic        [SAMPLE_BITS-1:0] mag;
    logic        [SAMPLE_BITS-1:0] mask;
    logic        [SAMPLE_BITS-1:0] mag_q;
    logic signed [6:0]             sh;

    // magnitude of the most negative sample still fits unsigned
    assign mag = i_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_x) : SAMPLE_BITS'(i_x);
    assign sh  = $signed(7'(SAMPLE_BITS - 1)) - $signed({2'b00, i_levels_log2});

    always_comb begin
        if (sh > 7'sd0) begin
            mask = {SAMPLE_BITS{1'b1}} << sh[4:0];
        end else begin
            mask = {SAMPLE_BITS{1'b1}};
        end
    end

    assign mag_q = mag & mask;
    assign o_q   = i_x[SAMPLE_BITS-1] ? $signed(-mag_q) : $signed(mag_q);

endmodule

FILE: hw/rtl/bcds_blend.sv
`timescale 1ns / 1ps

module bcds_blend #(
    parameter int SAMPLE_BITS   = bcds_pkg::BCDS_SAMPLE_BITS,
    parameter int FRACTION_BITS = bcds_pkg::BCDS_FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_a,
    input  logic signed [SAMPLE_BITS-1:0] i_b,
    input  logic        [FRACTION_BITS:0] i_w,
    output logic signed [SAMPLE_BITS-1:0] o_res
);
    import bcds_pkg::*;

    localparam int PW = SAMPLE_BITS + FRACTION_BITS + 3;
    localparam int QW = PW - FRACTION_BITS + 1;
    localparam logic signed [PW:0]   HALF = (PW+1)'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [QW-1:0] QMAX = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [QW-1:0] QMIN = ~QMAX;

    logic signed [SAMPLE_BITS:0]     diff;
    logic signed [FRACTION_BITS+1:0] w_s;
    logic signed [PW-1:0]            n_prod;
    logic signed [PW-1:0]            r_prod;
    logic signed [SAMPLE_BITS-1:0]   r_b;
    logic signed [PW:0]              sum;
    logic signed [QW-1:0]            q;

    // a*w + b*(one-w) = b*one + (a-b)*w
    assign diff   = (SAMPLE_BITS+1)'(i_a) - (SAMPLE_BITS+1)'(i_b);
    assign w_s    = $signed({1'b0, i_w});
    assign n_prod = diff * w_s;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= n_prod;
            r_b    <= i_b;
        end
    end

    assign sum = ((PW+1)'(r_b) <<< FRACTION_BITS) + (PW+1)'(r_prod) + HALF;
    assign q   = sum[PW:FRACTION_BITS];

    always_comb begin
        priority if (q > QMAX) begin
            o_res = QMAX[SAMPLE_BITS-1:0];
        end else if (q < QMIN) begin
            o_res = QMIN[SAMPLE_BITS-1:0];
        end else begin
            o_res = q[SAMPLE_BITS-1:0];
        end
    end

endmodule

FILE: hw/rtl/bitcrush_downsample.sv
`timescale 1ns / 1ps

// stereo bit crusher with sample-hold rate reduction
// input channel: i_in_valid / o_in_ready, one stereo pair per item (q1.15)
// output channel: o_out_valid / i_out_ready, one stereo pair per input item
// config: i_cfg_we writes i_cfg_data into register i_cfg_index,
//   indexes 0..4 are crush bits, crush fraction, hold length, hold fraction,
//   wet amount; other indexes are ignored. write only while the block is idle
// each item runs its weighted blends (crush and wet per channel, plus hold
//   per channel off the take slot) through one shared multiplier, the two
//   channels interleaved; the block takes no new item until the last one
//   has reached the output register
// o_out_valid rises once ST_DONE loads the output register, after the crush,
//   wet and, off the take slot, hold states
// results sit in an output register; a new item is accepted while the last
//   result waits, but the block holds its next result until that one is taken
// reset clears the hold counter and both held pairs, and loads the config
//   defaults: 16 bits, crush fraction 0, hold length 1, hold fraction 0,
//   fully wet
module bitcrush_downsample #(
    parameter int SAMPLE_BITS   = bcds_pkg::BCDS_SAMPLE_BITS,
    parameter int FRACTION_BITS = bcds_pkg::BCDS_FRACTION_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]          o_left_out,
    output logic signed [SAMPLE_BITS-1:0]          o_right_out,
    input  logic                                   i_cfg_we,
    input  logic        [bcds_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic        [FRACTION_BITS:0]          i_cfg_data
);
    import bcds_pkg::*;

    localparam logic [FRACTION_BITS:0] ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

    // configuration
    logic [4:0]               r_crush_bits;
    logic [FRACTION_BITS-1:0] r_crush_frac;
    logic [4:0]               r_hold_len;
    logic [FRACTION_BITS-1:0] r_hold_frac;
    logic [FRACTION_BITS:0]   r_wet;

    logic [4:0]             bits_eff;
    logic [4:0]             hold_eff;
    logic [FRACTION_BITS:0] wet_eff;

    t_state r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_x     [2];
    logic signed [SAMPLE_BITS-1:0] n_x     [2];
    logic signed [SAMPLE_BITS-1:0] r_cr    [2];
    logic signed [SAMPLE_BITS-1:0] n_cr    [2];
    logic signed [SAMPLE_BITS-1:0] r_m     [2];
    logic signed [SAMPLE_BITS-1:0] n_m     [2];
    logic signed [SAMPLE_BITS-1:0] r_h     [2];
    logic signed [SAMPLE_BITS-1:0] n_h     [2];
    logic signed [SAMPLE_BITS-1:0] r_newer [2];
    logic signed [SAMPLE_BITS-1:0] n_newer [2];
    logic signed [SAMPLE_BITS-1:0] r_older [2];
    logic signed [SAMPLE_BITS-1:0] n_older [2];
    logic signed [SAMPLE_BITS-1:0] r_out   [2];
    logic signed [SAMPLE_BITS-1:0] n_out   [2];
    logic                          r_out_valid, n_out_valid;
    logic                          r_take, n_take;
    logic                          r_upd, n_upd;
    logic [4:0]                    r_skip, n_skip;

    logic                          in_accept;
    logic signed [SAMPLE_BITS-1:0] ch_x;
    logic signed [SAMPLE_BITS-1:0] q_coarse;
    logic signed [SAMPLE_BITS-1:0] q_fine;
    logic                          bl_start;
    logic signed [SAMPLE_BITS-1:0] bl_a;
    logic signed [SAMPLE_BITS-1:0] bl_b;
    logic        [FRACTION_BITS:0] bl_w;
    logic signed [SAMPLE_BITS-1:0] bl_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crush_bits <= CRUSH_MAX;
            r_crush_frac <= '0;
            r_hold_len   <= 5'd1;
            r_hold_frac  <= '0;
            r_wet        <= ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CRUSH_BITS:     r_crush_bits <= i_cfg_data[4:0];
                CFG_CRUSH_FRACTION: r_crush_frac <= i_cfg_data[FRACTION_BITS-1:0];
                CFG_HOLD_LENGTH:    r_hold_len   <= i_cfg_data[4:0];
                CFG_HOLD_FRACTION:  r_hold_frac  <= i_cfg_data[FRACTION_BITS-1:0];
                CFG_WET_AMOUNT:     r_wet        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // out-of-range settings fold onto the nearest legal value
    always_comb begin
        priority if (r_crush_bits == 5'd0) begin
            bits_eff = 5'd1;
        end else if (r_crush_bits > CRUSH_MAX) begin
            bits_eff = CRUSH_MAX;
        end else begin
            bits_eff = r_crush_bits;
        end
        priority if (r_hold_len == 5'd0) begin
            hold_eff = 5'd1;
        end else if (r_hold_len > HOLD_MAX) begin
            hold_eff = HOLD_MAX;
        end else begin
            hold_eff = r_hold_len;
        end
        wet_eff = (r_wet > ONE) ? ONE : r_wet;
    end

    assign ch_x = (r_state == ST_CRUSH_R) ? r_x[1] : r_x[0];

    bcds_quant #(.SAMPLE_BITS(SAMPLE_BITS)) u_quant_coarse (
        .i_x           (ch_x),
        .i_levels_log2 (bits_eff - 5'd1),
        .o_q           (q_coarse)
    );

    bcds_quant #(.SAMPLE_BITS(SAMPLE_BITS)) u_quant_fine (
        .i_x           (ch_x),
        .i_levels_log2 (bits_eff),
        .o_q           (q_fine)
    );

    bcds_blend #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_start (bl_start),
        .i_a     (bl_a),
        .i_b     (bl_b),
        .i_w     (bl_w),
        .o_res   (bl_res)
    );

    assign in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_skip      <= '0;
            r_take      <= 1'b0;
            r_upd       <= 1'b0;
            r_newer     <= '{default: '0};
            r_older     <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_skip      <= n_skip;
            r_take      <= n_take;
            r_upd       <= n_upd;
            r_newer     <= n_newer;
            r_older     <= n_older;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_cr  <= n_cr;
        r_m   <= n_m;
        r_h   <= n_h;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_cr        = r_cr;
        n_m         = r_m;
        n_h         = r_h;
        n_newer     = r_newer;
        n_older     = r_older;
        n_out       = r_out;
        n_take      = r_take;
        n_upd       = r_upd;
        n_skip      = r_skip;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        bl_start    = 1'b0;
        bl_a        = q_coarse;
        bl_b        = q_fine;
        bl_w        = {1'b0, r_crush_frac};

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_x[0] = i_left_in;
                    n_x[1] = i_right_in;
                    // take when skip >= d-1, refresh older when skip >= d-2
                    n_take = ({1'b0, r_skip} + 6'd1) >= {1'b0, hold_eff};
                    n_upd  = ({1'b0, r_skip} + 6'd2) >= {1'b0, hold_eff};
                    n_skip = n_take ? 5'd0 : r_skip + 5'd1;
                    n_state = ST_CRUSH_L;
                end
            end
            ST_CRUSH_L: begin
                bl_start = 1'b1;
                n_state  = ST_CRUSH_R;
            end
            ST_CRUSH_R: begin
                n_cr[0]  = bl_res;
                bl_start = 1'b1;
                n_state  = ST_WET_L;
            end
            ST_WET_L: begin
                n_cr[1]  = bl_res;
                bl_start = 1'b1;
                bl_a     = r_cr[0];
                bl_b     = r_x[0];
                bl_w     = wet_eff;
                n_state  = ST_WET_R;
            end
            ST_WET_R: begin
                n_m[0]   = bl_res;
                bl_start = 1'b1;
                bl_a     = r_cr[1];
                bl_b     = r_x[1];
                bl_w     = wet_eff;
                n_state  = ST_HOLD_L;
            end
            ST_HOLD_L: begin
                n_m[1] = bl_res;
                if (r_take) begin
                    n_state = ST_DONE;
                end else begin
                    bl_start = 1'b1;
                    bl_a     = r_upd ? r_m[0] : r_older[0];
                    bl_b     = r_newer[0];
                    bl_w     = {1'b0, r_hold_frac};
                    if (r_upd) begin
                        n_older[0] = r_m[0];
                    end
                    n_state = ST_HOLD_R;
                end
            end
            ST_HOLD_R: begin
                n_h[0]   = bl_res;
                bl_start = 1'b1;
                bl_a     = r_upd ? r_m[1] : r_older[1];
                bl_b     = r_newer[1];
                bl_w     = {1'b0, r_hold_frac};
                if (r_upd) begin
                    n_older[1] = r_m[1];
                end
                n_state = ST_HOLD_FIN;
            end
            ST_HOLD_FIN: begin
                n_h[1]  = bl_res;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait for the previous result to leave
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_take ? r_m : r_h;
                    n_out_valid = 1'b1;
                    if (r_take) begin
                        n_newer = r_m;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out[0];
    assign o_right_out = r_out[1];

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_CRUSH_L) && !o_in_ready)
        else $error("accepted item did not start the sequencer");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result appeared outside the finishing step");

    a_skip_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip < HOLD_MAX)
        else $error("hold counter ran past the longest hold");

    a_take_refreshes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) && r_take |-> r_upd)
        else $error("take slot without older hold refresh condition");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bcds_pkg::*;

    localparam int SW = BCDS_SAMPLE_BITS;
    localparam int FW = BCDS_FRACTION_BITS;
    localparam longint FRAC_ONE = 64'sd1 << FW;
    localparam longint S_HI = 2 ** (SW - 1) - 1;
    localparam longint S_LO = -(2 ** (SW - 1));
    localparam logic signed [SW-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SW-1:0] SAMPLE_MIN = 16'sh8000;
    // indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS = 150;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic {ROW_WRITE, ROW_PAIR} t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [FW:0]               data;
        logic signed [SW-1:0]      left;
        logic signed [SW-1:0]      right;
        logic                      pinned;
        logic signed [SW-1:0]      want_left;
        logic signed [SW-1:0]      want_right;
    } t_stim_row;

    typedef struct packed {
        logic                 pinned;
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } t_pair;

    localparam int N_DIRECTED = 40;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // reset defaults pass every sample straight through
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, SAMPLE_MAX, SAMPLE_MIN},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MIN, SAMPLE_MAX, 1'b1, SAMPLE_MIN, SAMPLE_MAX},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh0000, 16'shFFFF, 1'b1, 16'sh0000, 16'shFFFF},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh5555, 16'shAAAA, 1'b1, 16'sh5555, 16'shAAAA},
        // one bit: magnitude keeps only its top two bits
        '{ROW_WRITE, CFG_CRUSH_BITS, 9'd1, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, 16'sh4000, SAMPLE_MIN},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sd20000, 16'shB1E0, 1'b1, 16'sh4000, 16'shC000},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sd100, 16'shFF9C, 1'b1, 16'sh0000, 16'sh0000},
        '{ROW_WRITE, CFG_CRUSH_FRACTION, 9'd255, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh1234, 16'shEDCB, 1'b0, 16'sh0, 16'sh0},
        // zero depth behaves as one
        '{ROW_WRITE, CFG_CRUSH_BITS, 9'd0, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sd20000, 16'shB1E0, 1'b0, 16'sh0, 16'sh0},
        // depth above sixteen clamps
        '{ROW_WRITE, CFG_CRUSH_BITS, 9'h1FF, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh4321, 16'shBCDE, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, CFG_CRUSH_BITS, 9'd9, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        // fully dry
        '{ROW_WRITE, CFG_WET_AMOUNT, 9'd0, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sd12345, 16'shCFC7, 1'b1, 16'sd12345, 16'shCFC7},
        // wet above full scale clamps
        '{ROW_WRITE, CFG_WET_AMOUNT, 9'h1FF, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sd12345, 16'shCFC7, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, CFG_WET_AMOUNT, 9'd128, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, CFG_HOLD_LENGTH, 9'd3, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, CFG_HOLD_FRACTION, 9'd128, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh7000, 16'sh9000, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh0800, 16'shF800, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh3000, 16'shC000, 1'b0, 16'sh0, 16'sh0},
        // zero hold length behaves as one
        '{ROW_WRITE, CFG_HOLD_LENGTH, 9'd0, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh2AAA, 16'shD555, 1'b0, 16'sh0, 16'sh0},
        // hold length 31 clamps to 30
        '{ROW_WRITE, CFG_HOLD_LENGTH, 9'h1FF, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, CFG_HOLD_FRACTION, 9'h1FF, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MAX, SAMPLE_MIN, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MIN, SAMPLE_MAX, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh1111, 16'shEEEE, 1'b0, 16'sh0, 16'sh0},
        // shorter hold while the counter is past it: next item is taken
        '{ROW_WRITE, CFG_HOLD_LENGTH, 9'd2, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh6000, 16'shA000, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, 16'sh0001, 16'shFFFE, 1'b0, 16'sh0, 16'sh0},
        // writes to unused indexes must change nothing
        '{ROW_WRITE, CFG_SPARE_LO, 9'h1FF, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_WRITE, CFG_SPARE_HI, 9'h000, 16'sh0, 16'sh0, 1'b0, 16'sh0, 16'sh0},
        '{ROW_PAIR,  CFG_CRUSH_BITS, 9'd0, SAMPLE_MAX, SAMPLE_MAX, 1'b0, 16'sh0, 16'sh0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic signed [SW-1:0]      i_left_in = '0;
    logic signed [SW-1:0]      i_right_in = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [SW-1:0]      o_left_out;
    logic signed [SW-1:0]      o_right_out;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [FW:0]               i_cfg_data = '0;

    // predictor registers and hold state, reset values
    logic [4:0] crush_bits_r = 5'd16;
    logic [7:0] crush_frac_r = 8'd0;
    logic [4:0] hold_length_r = 5'd1;
    logic [7:0] hold_frac_r = 8'd0;
    logic [8:0] wet_r = 9'd256;
    logic [4:0] skip_count = 5'd0;
    longint     newer_hold [2] = '{0, 0};
    longint     older_hold [2] = '{0, 0};

    t_pair pin_q [$];
    t_pair pending_pairs [$];
    int    errors = 0;
    int    cycle_count = 0;
    bit    gap_on = 1'b0;
    bit    stall_on = 1'b0;
    int    stall_left = 0;

    bitcrush_downsample dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint clamp_sample(longint v);
        if (v > S_HI) return S_HI;
        if (v < S_LO) return S_LO;
        return v;
    endfunction

    // truncate magnitude toward zero at 2^lv levels
    function automatic longint quantize(longint x, int lv);
        int     s;
        longint mag;
        s = SW - 1 - lv;
        if (s <= 0) return x;
        mag = (x < 0) ? -x : x;
        mag = (mag >> s) << s;
        return (x < 0) ? -mag : mag;
    endfunction

    // a*w + b*(one-w), round half up, saturate
    function automatic longint weigh(longint a, longint b, longint w);
        longint v;
        v = a * w + b * (FRAC_ONE - w) + FRAC_ONE / 2;
        return clamp_sample(v >>> FW);
    endfunction

    function automatic t_pair crush_hold_pair(logic signed [SW-1:0] left,
                                              logic signed [SW-1:0] right);
        int     depth;
        int     len;
        int     sc;
        bit     take;
        longint wet;
        longint x;
        longint cr;
        longint m;
        longint res [2];
        t_pair  result;
        depth = crush_bits_r;
        if (depth < 1) depth = 1;
        if (depth > CRUSH_MAX) depth = CRUSH_MAX;
        len = hold_length_r;
        if (len < 1) len = 1;
        if (len > HOLD_MAX) len = HOLD_MAX;
        wet = wet_r;
        if (wet > FRAC_ONE) wet = FRAC_ONE;
        sc = skip_count;
        take = sc >= len - 1;
        for (int c = 0; c < 2; c++) begin
            x = (c == 0) ? longint'(left) : longint'(right);
            cr = weigh(quantize(x, depth - 1), quantize(x, depth), crush_frac_r);
            m = weigh(cr, x, wet);
            if (take) begin
                newer_hold[c] = m;
                res[c] = m;
            end else begin
                if (sc >= len - 2) older_hold[c] = m;
                res[c] = weigh(older_hold[c], newer_hold[c], hold_frac_r);
            end
        end
        skip_count = take ? 5'd0 : 5'(sc + 1);
        result.pinned = 1'b0;
        result.left = SW'(res[0]);
        result.right = SW'(res[1]);
        return result;
    endfunction

    always @(posedge i_clk) begin
        t_pair want;
        t_pair pin;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CRUSH_BITS:     crush_bits_r = i_cfg_data[4:0];
                    CFG_CRUSH_FRACTION: crush_frac_r = i_cfg_data[7:0];
                    CFG_HOLD_LENGTH:    hold_length_r = i_cfg_data[4:0];
                    CFG_HOLD_FRACTION:  hold_frac_r = i_cfg_data[7:0];
                    CFG_WET_AMOUNT:     wet_r = i_cfg_data;
                    default: ;
                endcase
            end
            // check before pushing so a new item never matches its own result
            if (o_out_valid && i_out_ready) begin
                if (pending_pairs.size() == 0) begin
                    $error("result with no item pending: left_out %0d right_out %0d",
                           o_left_out, o_right_out);
                    errors++;
                end else begin
                    want = pending_pairs.pop_front();
                    if (o_left_out !== want.left) begin
                        $error("left_out: expected %0d, got %0d", want.left, o_left_out);
                        errors++;
                    end
                    if (o_right_out !== want.right) begin
                        $error("right_out: expected %0d, got %0d", want.right, o_right_out);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                pin = pin_q.pop_front();
                want = crush_hold_pair(i_left_in, i_right_in);
                if (pin.pinned) want = pin;
                pending_pairs.push_back(want);
            end
        end
    end

    // receiver back-pressure in bursts, started at random while stall_on is set
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [FW:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_pair(input logic signed [SW-1:0] left, right, input logic pinned,
                             input logic signed [SW-1:0] want_l, want_r);
        if (gap_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        pin_q.push_back(t_pair'{pinned, want_l, want_r});
        i_in_valid <= 1'b1;
        i_left_in <= left;
        i_right_in <= right;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [FW:0] pick_value(int lo, int hi);
        case ($urandom_range(0, 3))
            0: return (FW+1)'(lo);
            1: return (FW+1)'(hi);
            2: return (FW+1)'($urandom);
            default: return (FW+1)'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        if ($urandom_range(0, 7) != 0) return SW'($urandom);
        case ($urandom_range(0, 4))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'sh0001;
        endcase
    endfunction

    task automatic randomize_config();
        if ($urandom_range(0, 4) != 0) write_reg(CFG_CRUSH_BITS, pick_value(1, 16));
        if ($urandom_range(0, 4) != 0) write_reg(CFG_CRUSH_FRACTION, pick_value(0, 255));
        if ($urandom_range(0, 4) != 0) write_reg(CFG_HOLD_LENGTH, pick_value(1, 30));
        if ($urandom_range(0, 4) != 0) write_reg(CFG_HOLD_FRACTION, pick_value(0, 255));
        if ($urandom_range(0, 4) != 0) write_reg(CFG_WET_AMOUNT, pick_value(0, 256));
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_INDEX_BITS'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                      (FW+1)'($urandom));
    endtask

    initial begin
        int  sent;
        int  burst;
        bit  calm;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        gap_on = 1'b1;
        stall_on <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            if (DIRECTED[r].kind == ROW_WRITE) begin
                drain_results();
                write_reg(DIRECTED[r].index, DIRECTED[r].data);
            end else begin
                send_pair(DIRECTED[r].left, DIRECTED[r].right, DIRECTED[r].pinned,
                          DIRECTED[r].want_left, DIRECTED[r].want_right);
            end
        end
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = sent >= RANDOM_ITEMS - CALM_ITEMS;
            gap_on = !calm && $urandom_range(0, 3) != 0;
            stall_on <= !calm && $urandom_range(0, 3) != 0;
            // the closing stretch keeps its settings and runs without pauses
            if (!calm) randomize_config();
            burst = $urandom_range(20, 60);
            repeat (burst) begin
                send_pair(rand_sample(), rand_sample(), 1'b0, 16'sh0, 16'sh0);
                sent++;
            end
            // every result back before the next register change
            if (!calm) drain_results();
        end
        drain_results();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
